// File: sv/lz10_pkg.sv
// Shared constants and controller/datapath interface types for the LZ10 decompressor.
package lz10_pkg;

  localparam int DEF_WINDOW_SIZE = 4096;
  localparam int DEF_LENGTH_BITS = 24;

  localparam int DIST_BITS       = 12;  // low bits of a reference give distance - 1
  localparam int COUNT_BITS      = 5;   // copy length 3..18
  localparam int TOKEN_BITS      = 4;   // tokens left, 0..8
  localparam int MIN_MATCH       = 3;
  localparam int TOKENS_PER_FLAG = 8;

  typedef struct packed {
    logic clear;        // new stream: zero the produced-byte count
    logic take;         // capture the accepted input byte
    logic set_hi;       // hold the captured byte as the reference high byte
    logic start_match;  // decode length and distance from high byte and captured byte
    logic lit;          // emit the captured byte as a literal
    logic rd;           // read history for the next copied byte
    logic cp;           // emit the copied byte
  } dp_cmd_t;

  typedef struct packed {
    logic       done;       // produced count has reached the length
    logic       end_next;   // the next emitted byte reaches the length
    logic       out_free;   // output register can load this cycle
    logic       copy_last;  // one byte left in the current copy
    logic [7:0] in_q;       // captured input byte
  } dp_stat_t;

endpackage

// File: sv/lz10_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lz10_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/lz10_datapath.sv
// Datapath: length register, byte counter, history RAM, copy counters and output register.
module lz10_datapath #(
  parameter int WINDOW_SIZE = lz10_pkg::DEF_WINDOW_SIZE,
  parameter int LENGTH_BITS = lz10_pkg::DEF_LENGTH_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [LENGTH_BITS-1:0] cfg_wdata,
  input  logic [7:0]             in_byte,
  input  lz10_pkg::dp_cmd_t      cmd,
  output lz10_pkg::dp_stat_t     stat,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,
  output logic                   m_axis_tlast,
  output logic [1:0]             m_axis_tuser
);

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam int DW = lz10_pkg::DIST_BITS + 1;
  localparam int CW = lz10_pkg::COUNT_BITS;

  logic [LENGTH_BITS-1:0] out_len;
  logic [LENGTH_BITS-1:0] produced;
  logic [7:0]             in_q;
  logic [7:0]             hi_q;
  logic [CW-1:0]          count;
  logic [DW-1:0]          ref_dist;
  logic                   out_valid;
  logic [7:0]             out_data;
  logic                   out_last;
  logic                   out_end;
  logic                   out_bad;

  logic [LENGTH_BITS:0]   produced_inc;
  logic                   end_next;
  logic                   ref_bad;
  logic [15:0]            info;
  logic [7:0]             rd_data;
  logic [7:0]             wr_data;
  logic                   wr_en;
  logic [AW-1:0]          rd_addr;

  assign produced_inc = {1'b0, produced} + {{LENGTH_BITS{1'b0}}, 1'b1};
  assign end_next     = produced_inc >= {1'b0, out_len};
  assign ref_bad      = produced < {{(LENGTH_BITS-DW){1'b0}}, ref_dist};
  assign info         = {hi_q, in_q};
  assign wr_en        = cmd.lit | cmd.cp;
  assign wr_data      = cmd.lit ? in_q : (ref_bad ? 8'h00 : rd_data);
  // ring index of produced - distance; a distance of the full window wraps onto itself
  assign rd_addr      = produced[AW-1:0] - ref_dist[AW-1:0];

  lz10_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_SIZE)
  ) u_hist (
    .clk   (clk),
    .we    (wr_en),
    .waddr (produced[AW-1:0]),
    .wdata (wr_data),
    .re    (cmd.rd),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_len   <= {{(LENGTH_BITS-1){1'b0}}, 1'b1};
      produced  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        out_len <= cfg_wdata;
      end
      if (cmd.clear) begin
        produced <= '0;
      end else if (wr_en) begin
        produced <= produced_inc[LENGTH_BITS-1:0];
      end
      if (wr_en) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      in_q <= in_byte;
    end
    if (cmd.set_hi) begin
      hi_q <= in_q;
    end
    if (cmd.start_match) begin
      count    <= CW'(lz10_pkg::MIN_MATCH) + {1'b0, info[15:12]};
      ref_dist <= {1'b0, info[11:0]} + DW'(1);
    end else if (cmd.cp) begin
      count <= count - CW'(1);
    end
    if (wr_en) begin
      out_data <= wr_data;
      out_last <= cmd.lit | (count == CW'(1)) | end_next;
      out_end  <= end_next;
      out_bad  <= cmd.cp & ref_bad;
    end
  end

  assign stat.done      = produced >= out_len;
  assign stat.end_next  = end_next;
  assign stat.out_free  = ~out_valid | m_axis_tready;
  assign stat.copy_last = count == CW'(1);
  assign stat.in_q      = in_q;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = {out_bad, out_end};

endmodule

// File: sv/lz10_ctrl.sv
// Controller: token parser and copy sequencer driving the datapath.
module lz10_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic               s_axis_tuser,
  input  lz10_pkg::dp_stat_t stat,
  output lz10_pkg::dp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_READ   = 2'd2;
  localparam logic [1:0] ST_COPY   = 2'd3;

  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_TOKEN = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;

  localparam int TB = lz10_pkg::TOKEN_BITS;

  logic [1:0]    state, state_next;
  logic [1:0]    phase, phase_next;
  logic [7:0]    flags, flags_next;
  logic [TB-1:0] tokens, tokens_next;
  logic          finished, finished_next;
  logic [TB-1:0] tokens_dec;

  assign tokens_dec = (tokens != '0) ? tokens - TB'(1) : '0;

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    flags_next    = flags;
    tokens_next   = tokens;
    finished_next = finished;
    cmd           = '0;
    s_axis_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.take   = 1'b1;
          state_next = ST_DECODE;
          if (s_axis_tuser) begin
            cmd.clear     = 1'b1;
            flags_next    = '0;
            tokens_next   = '0;
            phase_next    = PH_FLAG;
            finished_next = 1'b0;
          end
        end
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        if (finished || stat.done) begin
          finished_next = 1'b1;
        end else begin
          case (phase)
            PH_FLAG: begin
              flags_next  = stat.in_q;
              tokens_next = TB'(lz10_pkg::TOKENS_PER_FLAG);
              phase_next  = PH_TOKEN;
            end
            PH_TOKEN: begin
              if (flags[7]) begin
                cmd.set_hi = 1'b1;
                phase_next = PH_LOW;
              end else if (stat.out_free) begin
                cmd.lit       = 1'b1;
                finished_next = stat.end_next;
                flags_next    = {flags[6:0], 1'b0};
                tokens_next   = tokens_dec;
                phase_next    = (tokens_dec == '0) ? PH_FLAG : PH_TOKEN;
              end else begin
                state_next = ST_DECODE;  // wait for the output register
              end
            end
            PH_LOW: begin
              cmd.start_match = 1'b1;
              flags_next      = {flags[6:0], 1'b0};
              tokens_next     = tokens_dec;
              phase_next      = (tokens_dec == '0) ? PH_FLAG : PH_TOKEN;
              state_next      = ST_READ;
            end
            default: begin
              phase_next = PH_FLAG;
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_COPY;
      end
      ST_COPY: begin
        if (stat.out_free) begin
          cmd.cp = 1'b1;
          if (stat.end_next) begin
            finished_next = 1'b1;
          end
          state_next = (stat.copy_last || stat.end_next) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_FLAG;
      flags    <= '0;
      tokens   <= '0;
      finished <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      flags    <= flags_next;
      tokens   <= tokens_next;
      finished <= finished_next;
    end
  end

endmodule

// File: sv/lz10_decompressor.sv
// Top level of the LZ10 decompressor: controller plus datapath.
//
//   port group   dir  tdata              tuser                          tlast
//   s_axis       in   in_byte[7:0]       start_of_stream                -
//   m_axis       out  out_byte[7:0]      [0] end_of_data [1] bad_ref    last_of_run
//   cfg          in   output_length      (write enable cfg_wen)         -
//
// Each input byte is accepted, then decoded. A back-reference then copies each
// byte by a history RAM read, then a write and output load, and holds the input
// until its last copied byte is loaded.
// Output stalls hold the controller in decode or copy until the output register frees.
// Reset is synchronous; history contents are not cleared and need no clearing pass.
module lz10_decompressor #(
  parameter int WINDOW_SIZE = lz10_pkg::DEF_WINDOW_SIZE,
  parameter int LENGTH_BITS = lz10_pkg::DEF_LENGTH_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [LENGTH_BITS-1:0] cfg_wdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // in_byte
  input  logic                   s_axis_tuser,   // start_of_stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // out_byte
  output logic                   m_axis_tlast,   // last_of_run
  output logic [1:0]             m_axis_tuser    // [0] end_of_data, [1] bad_reference
);

  lz10_pkg::dp_cmd_t  cmd;
  lz10_pkg::dp_stat_t stat;

  lz10_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .stat          (stat),
    .cmd           (cmd)
  );

  lz10_datapath #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .in_byte       (s_axis_tdata),
    .cmd           (cmd),
    .stat          (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: sv/lz10_checker.sv
// Port-level checker for the LZ10 decompressor, bound to the top level.
module lz10_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [1:0] m_axis_tuser
);

  // a stalled output transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("output payload changed while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 8'h00)
    else $error("bad reference byte is not zero");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("end of data without last of run");

  // each accepted byte passes through decode before the next transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind lz10_decompressor lz10_checker u_lz10_checker (.*);

// File: verif/lz10_decompressor_test.sv
// Self-checking testbench for lz10_decompressor: predicted byte stream vs. m_axis output.
module lz10_decompressor_test;

  typedef struct packed {
    logic [7:0] data;
    logic       sos;
  } comp_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       stream_end;
    logic       bad_ref;
  } plain_byte_t;

  typedef enum logic [1:0] {WANT_FLAG, WANT_TOKEN, WANT_LOW} token_phase_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [23:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // in_byte
  logic        s_axis_tuser = 1'b0; // start_of_stream
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // out_byte
  logic        m_axis_tlast;        // last_of_run
  logic [1:0]  m_axis_tuser;        // [0] end_of_data, [1] bad_reference

  lz10_decompressor dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("lz10_decompressor_test: errors");
    $finish;
  end

  comp_byte_t  staged[$];
  comp_byte_t  pending_bytes[$];
  plain_byte_t expected_bytes[$];
  plain_byte_t run_buf[$];

  comp_byte_t cur_byte = '0;
  bit         feeding = 1'b0;
  bit         calm = 1'b0;
  int         in_gap = 0;
  int         out_gap = 0;
  int         errors = 0;
  int         decoded_items = 0;

  // decoder mirror
  logic [7:0]   hist [lz10_pkg::DEF_WINDOW_SIZE];
  logic [7:0]   flags = '0;
  logic [3:0]   toks_left = '0;
  token_phase_e tok_phase = WANT_FLAG;
  logic [7:0]   ref_hi = '0;
  logic [23:0]  produced = '0;
  logic         done_flag = 1'b0;
  logic [23:0]  out_len = 24'd1;

  task automatic emit(input logic [7:0] b, input logic bad);
    plain_byte_t e;
    hist[produced[11:0]] = b;
    produced = produced + 24'd1;
    e.data       = b;
    e.run_end    = 1'b0;
    e.stream_end = (produced >= out_len);
    e.bad_ref    = bad;
    if (e.stream_end) done_flag = 1'b1;
    run_buf.push_back(e);
  endtask

  task automatic shift_flags();
    flags = flags << 1;
    if (toks_left > 0) toks_left--;
    tok_phase = (toks_left == 0) ? WANT_FLAG : WANT_TOKEN;
  endtask

  task automatic decode_byte(input comp_byte_t c);
    logic [15:0] info;
    int          count;
    logic [23:0] ref_dist;
    logic [23:0] src;
    plain_byte_t e;
    run_buf.delete();
    if (c.sos) begin
      flags     = '0;
      toks_left = '0;
      tok_phase = WANT_FLAG;
      ref_hi    = '0;
      produced  = '0;
      done_flag = 1'b0;
    end
    if (produced >= out_len) done_flag = 1'b1;
    if (!done_flag) begin
      decoded_items++;
      case (tok_phase)
        WANT_FLAG: begin
          flags     = c.data;
          toks_left = 4'(lz10_pkg::TOKENS_PER_FLAG);
          tok_phase = WANT_TOKEN;
        end
        WANT_TOKEN: begin
          if (flags[7]) begin
            ref_hi    = c.data;
            tok_phase = WANT_LOW;
          end else begin
            emit(c.data, 1'b0);
            shift_flags();
          end
        end
        default: begin
          info     = {ref_hi, c.data};
          count    = lz10_pkg::MIN_MATCH + int'(info[15:12]);
          ref_dist = 24'(info[11:0]) + 24'd1;
          for (int i = 0; i < count && !done_flag; i++) begin
            // a reference reaching before the stream start yields zero
            if (produced < ref_dist) begin
              emit(8'h00, 1'b1);
            end else begin
              src = produced - ref_dist;
              emit(hist[src[11:0]], 1'b0);
            end
          end
          shift_flags();
        end
      endcase
    end
    if (run_buf.size() > 0) begin
      e = run_buf.pop_back();
      e.run_end = 1'b1;
      run_buf.push_back(e);
    end
    foreach (run_buf[i]) expected_bytes.push_back(run_buf[i]);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      feeding = 1'b0;
      in_gap = 0;
      s_axis_tvalid <= 1'b0;
    end else begin
      if (feeding && s_axis_tready) begin
        decode_byte(cur_byte);
        feeding = 1'b0;
      end
      if (!feeding) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_bytes.size() > 0) begin
          if (!calm && $urandom_range(0, 9) == 0) begin
            in_gap = $urandom_range(1, 13) - 1;
          end else begin
            cur_byte = pending_bytes.pop_front();
            feeding = 1'b1;
          end
        end
      end
      s_axis_tvalid <= feeding;
      s_axis_tdata  <= cur_byte.data;
      s_axis_tuser  <= cur_byte.sos;
    end
  end

  // output monitor
  always @(posedge clk) begin
    plain_byte_t want;
    plain_byte_t got;
    if (rst) begin
      out_gap = 0;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1]};
        if (expected_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer: data %h last %b end %b bad %b", $time,
                   got.data, got.run_end, got.stream_end, got.bad_ref);
        end else begin
          want = expected_bytes.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch: expected data %h last %b end %b bad %b, got data %h last %b end %b bad %b",
                     $time, want.data, want.run_end, want.stream_end, want.bad_ref,
                     got.data, got.run_end, got.stream_end, got.bad_ref);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 13) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] d, input logic sos);
    staged.push_back('{d, sos});
  endtask

  task automatic launch();
    @(negedge clk);
    foreach (staged[i]) pending_bytes.push_back(staged[i]);
    staged.delete();
  endtask

  // all input taken, all output seen, then let the block drain
  task automatic settle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || feeding || expected_bytes.size() != 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_length(input logic [23:0] v);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    out_len = v;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // token stream with random content, well-formed unless cut drops the last low byte; made = bytes of the uncut stream
  task automatic gen_stream(input int n_tokens, input bit cut, output int made);
    logic [7:0]  flag;
    logic [3:0]  len;
    logic [11:0] dcode;
    int          gen;
    int          reach;
    gen = 0;
    flag = '0;
    for (int t = 0; t < n_tokens; t++) begin
      if (t % 8 == 0) begin
        flag = 8'($urandom);
        queue_byte(flag, t == 0);
      end
      if (flag[7 - (t % 8)]) begin
        len = 4'($urandom_range(0, 15));
        reach = (gen > lz10_pkg::DEF_WINDOW_SIZE) ? lz10_pkg::DEF_WINDOW_SIZE : gen;
        if (gen == 0 || $urandom_range(0, 4) == 0)
          dcode = 12'($urandom_range(0, 4095));
        else if ($urandom_range(0, 2) == 0)
          dcode = 12'($urandom_range(1, (reach > 18) ? 18 : reach) - 1);  // overlapping copy
        else
          dcode = 12'($urandom_range(1, reach) - 1);
        queue_byte({len, dcode[11:8]}, 1'b0);
        if (!(cut && t == n_tokens - 1)) queue_byte(dcode[7:0], 1'b0);
        gen += lz10_pkg::MIN_MATCH + int'(len);
      end else begin
        queue_byte(8'($urandom), 1'b0);
        gen++;
      end
    end
    made = gen;
  endtask

  initial begin
    int base;
    int made;
    int pick;
    logic [23:0] len_val;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset length of one byte; later bytes are dropped
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    launch();
    settle();

    // refs before start, overlapping copy, max distance, truncated copy
    write_length(24'd40);
    queue_byte(8'hBC, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hA5, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h0F, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h15, 1'b0);
    queue_byte(8'h5A, 1'b0);
    launch();
    settle();

    // zero length: nothing comes out
    write_length(24'd0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h33, 1'b0);
    launch();
    settle();

    write_length(24'hFFFFFF);
    queue_byte(8'h40, 1'b1);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h20, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b0);
    launch();
    settle();

    // length dropped below the count mid-stream, then raised: stream stays finished
    write_length(24'd3);
    queue_byte(8'h11, 1'b0);
    launch();
    settle();
    write_length(24'd20);
    queue_byte(8'h22, 1'b0);
    launch();
    settle();

    base = decoded_items;
    while (decoded_items - base < 380) begin
      if (decoded_items - base > 300) calm = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        write_length(24'($urandom_range(1, 200)));
        repeat ($urandom_range(5, 25)) queue_byte(8'($urandom), $urandom_range(0, 7) == 0);
        launch();
        settle();
      end else if (pick == 1) begin
        gen_stream($urandom_range(4, 30), 1'b0, made);
        write_length(24'(made + 5));
        launch();
        settle();
        write_length(24'($urandom_range(1, made)));
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom), 1'b0);
        launch();
        settle();
      end else begin
        gen_stream($urandom_range(1, 40), $urandom_range(0, 5) == 0, made);
        case ($urandom_range(0, 9))
          0:       len_val = 24'd1;
          1:       len_val = 24'hFFFFFF;
          2, 3, 4: len_val = 24'(made);
          5, 6:    len_val = 24'($urandom_range(1, made));
          default: len_val = 24'(made + $urandom_range(1, 20));
        endcase
        write_length(len_val);
        launch();
        settle();
      end
    end

    if (errors == 0) begin
      $display("lz10_decompressor_test: clean");
    end else begin
      $display("lz10_decompressor_test: errors");
    end
    $finish;
  end

endmodule
